/* rtl/mclr_pkg.sv */
`default_nettype none
package mclr_pkg;

    localparam int CHANNELS_DEF = 16;
    localparam int MAX_RESULTS = 16;
    localparam logic [15:0] DURATION_RST = 16'd250;

    localparam logic [2:0] OP_TICK = 3'd0;
    localparam logic [2:0] OP_ANIMATE = 3'd1;
    localparam logic [2:0] OP_SET = 3'd2;
    localparam logic [2:0] OP_STOP = 3'd3;
    localparam logic [2:0] OP_READ = 3'd4;

    typedef struct packed {
        logic [2:0]         operation;
        logic [7:0]         channel;
        logic signed [31:0] new_value;
        logic [31:0]        now_ms;
    } t_in;

    typedef struct packed {
        logic [7:0]         out_channel;
        logic signed [31:0] out_value;
        logic               is_read;
        logic               last;
        logic               still_ramping;
    } t_out;

    typedef struct packed {
        logic signed [31:0] cur;
        logic signed [31:0] tgt;
        logic signed [31:0] st;
        logic [31:0]        stamp;
    } t_entry;

    typedef struct packed {
        logic [7:0]         ch;
        logic signed [31:0] val;
    } t_qent;

endpackage
`default_nettype wire

/* rtl/mclr_ram.sv */
`default_nettype none
module mclr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule
`default_nettype wire

/* rtl/mclr_div.sv */
`default_nettype none
module mclr_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [48:0] i_dividend,
    input  wire logic [15:0]        i_divisor,
    output logic                    o_done,
    output logic signed [32:0]      o_quotient
);
    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [16:0] r_rem;
    logic [48:0] r_dvd;
    logic [15:0] r_dsr;
    logic        r_neg;
    logic [16:0] rem_sh;
    logic        ge;

    assign rem_sh = {r_rem[15:0], r_dvd[48]};
    assign ge = rem_sh >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= 6'd49;
                r_rem <= '0;
                r_dsr <= i_divisor;
                r_neg <= i_dividend[48];
                r_dvd <= i_dividend[48] ? 49'(-i_dividend) : i_dividend;
            end else if (r_busy) begin
                r_rem <= ge ? (rem_sh - {1'b0, r_dsr}) : rem_sh;
                r_dvd <= {r_dvd[47:0], ge};
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quotient = r_neg ? -$signed(r_dvd[32:0]) : $signed(r_dvd[32:0]);
endmodule
`default_nettype wire

/* rtl/multi_channel_linear_ramp.sv */
// tick: a channel not ramping is skipped, one that has landed takes its target, and one
// still ramping is interpolated (49-step serial divide); results are then reported, one beat each
// throughput: one item at a time; input stalls until the item's last beat is registered
// reset: synchronous, clears control, ramping and written flags; duration_ms becomes 250
// levels of a channel never written read as zero
`default_nettype none
module multi_channel_linear_ramp #(
    parameter int CHANNELS = mclr_pkg::CHANNELS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire mclr_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output mclr_pkg::t_out      o_out_data,
    input  wire logic           i_cfg_we,
    input  wire logic [15:0]    i_cfg_data
);
    import mclr_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int QW = $clog2(MAX_RESULTS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TRD = 3'd1;
    localparam logic [2:0] S_TCALC = 3'd2;
    localparam logic [2:0] S_TDIV = 3'd3;
    localparam logic [2:0] S_AWR = 3'd4;
    localparam logic [2:0] S_ROUT = 3'd5;
    localparam logic [2:0] S_DRD = 3'd6;
    localparam logic [2:0] S_DOUT = 3'd7;

    logic [2:0]          r_state;
    logic [2:0]          r_op;
    logic [7:0]          r_ch;
    logic signed [31:0]  r_val;
    logic [31:0]         r_now;
    logic                r_fromram;
    logic                r_isread;
    logic [CH_W-1:0]     r_idx;
    logic [CHANNELS-1:0] r_ramp;
    logic [CHANNELS-1:0] r_wrtn;
    logic [15:0]         r_dur;
    logic [QW:0]         r_qcnt;
    logic [QW-1:0]       r_qrd;
    logic                r_ov;
    t_out                r_out;

    logic            acc;
    logic            in_ok;
    logic [CH_W-1:0] in_addr;
    logic [CH_W-1:0] ch_addr;
    logic            out_free;
    logic            out_load;

    logic            ram_we;
    logic            ram_re;
    logic [CH_W-1:0] ram_waddr;
    logic [CH_W-1:0] ram_raddr;
    t_entry          ram_wdata;
    t_entry          ram_q;
    logic signed [31:0] cur_m;

    logic [31:0]        el;
    logic               land;
    logic signed [32:0] diff;
    logic signed [48:0] prod;
    logic               div_start;
    logic               div_done;
    logic signed [32:0] quot;
    logic signed [31:0] lvl;

    logic   push;
    logic   q_we;
    logic   q_re;
    t_qent  q_wdata;
    t_qent  q_rdata;
    logic   last_ch;
    logic   q_last;

    assign acc = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign in_ok = ({1'b0, i_in_data.channel} < 9'(CHANNELS));
    assign in_addr = i_in_data.channel[CH_W-1:0];
    assign ch_addr = r_ch[CH_W-1:0];
    assign out_free = !r_ov || !i_out_stall;
    assign out_load = ((r_state == S_ROUT) || (r_state == S_DOUT)) && out_free;

    assign cur_m = r_wrtn[ch_addr] ? ram_q.cur : 32'sd0;
    assign el = r_now - ram_q.stamp;
    assign land = el >= {16'd0, r_dur};
    assign diff = 33'(ram_q.tgt) - 33'(ram_q.st);
    assign prod = diff * $signed({1'b0, el[15:0]});
    assign div_start = (r_state == S_TCALC) && !land;
    assign lvl = (r_state == S_TCALC) ? ram_q.tgt : 32'(ram_q.st + quot[31:0]);
    assign push = ((r_state == S_TCALC) && land) || ((r_state == S_TDIV) && div_done);
    assign q_we = push && (r_qcnt < (QW+1)'(MAX_RESULTS));
    assign q_re = (r_state == S_DRD);
    assign q_wdata = '{ch: 8'(r_idx), val: lvl};
    assign last_ch = (r_idx == CH_W'(CHANNELS - 1));
    assign q_last = ((QW+1)'(r_qrd) + (QW+1)'(1)) == r_qcnt;

    always_comb begin
        ram_re = 1'b0;
        ram_raddr = r_idx;
        ram_we = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = ram_q;
        case (r_state)
            S_IDLE: begin
                if (acc && (i_in_data.operation == OP_ANIMATE ||
                            i_in_data.operation == OP_READ)) begin
                    ram_re = 1'b1;
                    ram_raddr = in_addr;
                end
                if (acc && i_in_data.operation == OP_SET && in_ok) begin
                    ram_we = 1'b1;
                    ram_waddr = in_addr;
                    ram_wdata = '{cur: i_in_data.new_value, tgt: i_in_data.new_value,
                                  st: i_in_data.new_value, stamp: i_in_data.now_ms};
                end
            end
            S_TRD: begin
                ram_re = r_ramp[r_idx];
            end
            S_AWR: begin
                ram_we = 1'b1;
                ram_waddr = ch_addr;
                ram_wdata = '{cur: cur_m, tgt: r_val, st: cur_m, stamp: r_now};
            end
            S_TCALC, S_TDIV: begin
                ram_we = push;
                ram_wdata.cur = lvl;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ramp <= '0;
            r_wrtn <= '0;
            r_dur <= DURATION_RST;
            r_ov <= 1'b0;
            r_qcnt <= '0;
            r_qrd <= '0;
            r_idx <= '0;
        end else begin
            if (i_cfg_we) begin
                r_dur <= i_cfg_data;
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            if (q_we) begin
                r_qcnt <= r_qcnt + (QW+1)'(1);
            end
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_op <= i_in_data.operation;
                        r_ch <= i_in_data.channel;
                        r_now <= i_in_data.now_ms;
                        r_val <= (i_in_data.operation == OP_READ) ? 32'sd0
                                                                  : i_in_data.new_value;
                        r_isread <= (i_in_data.operation == OP_READ);
                        r_fromram <= (i_in_data.operation == OP_READ) && in_ok;
                        case (i_in_data.operation)
                            OP_TICK: begin
                                if (|r_ramp) begin
                                    r_idx <= '0;
                                    r_qcnt <= '0;
                                    r_state <= S_TRD;
                                end
                            end
                            OP_ANIMATE: begin
                                if (in_ok) begin
                                    r_state <= S_AWR;
                                end
                            end
                            OP_SET: begin
                                if (in_ok) begin
                                    r_ramp[in_addr] <= 1'b0;
                                    r_wrtn[in_addr] <= 1'b1;
                                    r_state <= S_ROUT;
                                end
                            end
                            OP_STOP: begin
                                r_ramp <= '0;
                            end
                            OP_READ: begin
                                r_state <= S_ROUT;
                            end
                            default: ;
                        endcase
                    end
                end
                S_AWR: begin
                    r_ramp[ch_addr] <= 1'b1;
                    r_wrtn[ch_addr] <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_ROUT: begin
                    if (out_free) begin
                        r_out <= '{out_channel: r_ch,
                                   out_value: r_fromram ? cur_m : r_val,
                                   is_read: r_isread, last: 1'b1,
                                   still_ramping: |r_ramp};
                        r_state <= S_IDLE;
                    end
                end
                S_TRD, S_TCALC, S_TDIV: begin
                    if ((r_state == S_TRD && !r_ramp[r_idx]) || push) begin
                        if (last_ch) begin
                            r_qrd <= '0;
                            r_state <= S_DRD;
                        end else begin
                            r_idx <= r_idx + CH_W'(1);
                            r_state <= S_TRD;
                        end
                    end else if (r_state == S_TRD) begin
                        r_state <= S_TCALC;
                    end else if (div_start) begin
                        r_state <= S_TDIV;
                    end
                    if (r_state == S_TCALC && land) begin
                        r_ramp[r_idx] <= 1'b0;
                    end
                end
                S_DRD: begin
                    r_state <= S_DOUT;
                end
                S_DOUT: begin
                    if (out_free) begin
                        r_out <= '{out_channel: q_rdata.ch, out_value: q_rdata.val,
                                   is_read: 1'b0, last: q_last,
                                   still_ramping: |r_ramp};
                        if (q_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_qrd <= r_qrd + QW'(1);
                            r_state <= S_DRD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    mclr_ram #(
        .WIDTH($bits(t_entry)),
        .DEPTH(CHANNELS)
    ) u_state_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_q)
    );

    mclr_ram #(
        .WIDTH($bits(t_qent)),
        .DEPTH(MAX_RESULTS)
    ) u_result_ram (
        .i_clk  (i_clk),
        .i_we   (q_we),
        .i_waddr(r_qcnt[QW-1:0]),
        .i_wdata(q_wdata),
        .i_re   (q_re),
        .i_raddr(r_qrd),
        .o_rdata(q_rdata)
    );

    mclr_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(prod),
        .i_divisor (r_dur),
        .o_done    (div_done),
        .o_quotient(quot)
    );

    assign o_out_valid = r_ov;
    assign o_out_data = r_out;
endmodule
`default_nettype wire
